[src/rlsf_pkg.sv]
`default_nettype none

package rlsf_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int CNT_W       = 8;
    localparam int CMD_W       = 2;
    localparam int ST_W        = 2;

    localparam logic [CNT_W-1:0] MAX_POINTS = 8'd255;

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [ST_W-1:0] ST_DEGEN  = 2'd2;
    localparam logic [ST_W-1:0] ST_REJECT = 2'd3;

    // running sums
    localparam int SX_W  = 24;
    localparam int SXX_W = 38;
    localparam int SXY_W = 39;
    localparam int XX_W  = 2 * COORD_WIDTH;

    // shared multiplier: 25-bit signed a times one half of a 39-bit signed b
    localparam int A_W    = 25;
    localparam int B_W    = 39;
    localparam int B_LO_W = 19;
    localparam int B_HI_W = B_W - B_LO_W;
    localparam int BP_W   = B_HI_W + 1;
    localparam int PROD_W = A_W + BP_W;
    localparam int ACC_W  = 64;
    localparam int DEN_W  = 48;

    // divider
    localparam int Q_W        = 32;
    localparam int SLOPE_FRAC = 16;
    localparam int DIV_CNT_W  = 5;

    // micro-step sequence
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_XY_LAST   = 4'd3;
    localparam logic [STEP_W-1:0] STEP_FIT_FIRST = 4'd4;
    localparam logic [STEP_W-1:0] STEP_FIT_LAST  = 4'd15;

    typedef enum logic [1:0] {
        A_X,
        A_N,
        A_SX,
        A_SY
    } a_sel_t;

    typedef enum logic [2:0] {
        B_X,
        B_Y,
        B_SXX,
        B_SX,
        B_SY,
        B_SXY
    } b_sel_t;

    typedef enum logic [2:0] {
        D_XX,
        D_XY,
        D_DEN,
        D_SNUM,
        D_INUM
    } dst_t;

    typedef struct packed {
        a_sel_t a_sel;
        b_sel_t b_sel;
        logic   hi;
        logic   neg;
        logic   last;
        dst_t   dst;
    } mac_op_t;

    typedef struct packed {
        logic [CNT_W-1:0] n;
        logic [SX_W-1:0]  sx;
        logic [SX_W-1:0]  sy;
        logic [SXX_W-1:0] sxx;
        logic [SXY_W-1:0] sxy;
    } sums_t;

    typedef struct packed {
        logic [XX_W-1:0]  xx;
        logic [XX_W-1:0]  xy;
        logic [DEN_W-1:0] den;
        logic [DEN_W-1:0] snum;
        logic [ACC_W-1:0] inum;
    } mac_res_t;

    typedef struct packed {
        logic             start;
        logic             frac;
        logic [ACC_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic           done;
        logic [Q_W-1:0] quo;
    } div_rsp_t;

    // each product takes two steps, high half of b first
    function automatic mac_op_t mac_op(input logic [STEP_W-1:0] step);
        mac_op_t op;
        logic    fin;
        op.a_sel = A_X;
        op.b_sel = B_X;
        op.neg   = 1'b0;
        op.dst   = D_XX;
        fin      = 1'b1;
        unique case (step[STEP_W-1:1])
            3'd0:
            begin
                op.a_sel = A_X;  op.b_sel = B_X;   op.neg = 1'b0; op.dst = D_XX;   fin = 1'b1;
            end
            3'd1:
            begin
                op.a_sel = A_X;  op.b_sel = B_Y;   op.neg = 1'b0; op.dst = D_XY;   fin = 1'b1;
            end
            3'd2:
            begin
                op.a_sel = A_N;  op.b_sel = B_SXX; op.neg = 1'b0; op.dst = D_DEN;  fin = 1'b0;
            end
            3'd3:
            begin
                op.a_sel = A_SX; op.b_sel = B_SX;  op.neg = 1'b1; op.dst = D_DEN;  fin = 1'b1;
            end
            3'd4:
            begin
                op.a_sel = A_N;  op.b_sel = B_SXY; op.neg = 1'b0; op.dst = D_SNUM; fin = 1'b0;
            end
            3'd5:
            begin
                op.a_sel = A_SX; op.b_sel = B_SY;  op.neg = 1'b1; op.dst = D_SNUM; fin = 1'b1;
            end
            3'd6:
            begin
                op.a_sel = A_SY; op.b_sel = B_SXX; op.neg = 1'b0; op.dst = D_INUM; fin = 1'b0;
            end
            3'd7:
            begin
                op.a_sel = A_SX; op.b_sel = B_SXY; op.neg = 1'b1; op.dst = D_INUM; fin = 1'b1;
            end
        endcase
        op.hi   = ~step[0];
        op.last = fin & step[0];
        return op;
    endfunction

endpackage

`default_nettype wire

[src/rlsf_mac.sv]
`default_nettype none

module rlsf_mac (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   issue,
    input  logic [rlsf_pkg::STEP_W-1:0]            step,
    input  logic signed [rlsf_pkg::COORD_WIDTH-1:0] x,
    input  logic signed [rlsf_pkg::COORD_WIDTH-1:0] y,
    input  rlsf_pkg::sums_t                        sums,
    output rlsf_pkg::mac_res_t                     res
);
    import rlsf_pkg::*;

    mac_op_t                  op;
    logic signed [A_W-1:0]    a_val;
    logic [B_W-1:0]           b_full;
    logic signed [BP_W-1:0]   b_part;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_reg;
    mac_op_t                  pop_reg;
    logic                     pend_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic [ACC_W-1:0]         acc_next;
    logic [ACC_W-1:0]         prod_ext;
    logic [ACC_W-1:0]         term;
    logic [ACC_W-1:0]         acc_sum;
    mac_res_t                 res_reg;
    mac_res_t                 res_next;

    assign op = mac_op(step);

    always_comb
    begin
        unique case (op.a_sel)
            A_X:  a_val = A_W'(x);
            A_N:  a_val = A_W'(sums.n);
            A_SX: a_val = A_W'($signed(sums.sx));
            A_SY: a_val = A_W'($signed(sums.sy));
        endcase
    end

    always_comb
    begin
        unique case (op.b_sel)
            B_X:     b_full = B_W'(x);
            B_Y:     b_full = B_W'(y);
            B_SXX:   b_full = B_W'(sums.sxx);
            B_SX:    b_full = B_W'($signed(sums.sx));
            B_SY:    b_full = B_W'($signed(sums.sy));
            B_SXY:   b_full = sums.sxy;
            default: b_full = '0;
        endcase
    end

    always_comb
    begin
        if (op.hi)
        begin
            b_part = BP_W'($signed(b_full[B_W-1:B_LO_W]));
        end
        else
        begin
            b_part = BP_W'(b_full[B_LO_W-1:0]);
        end
    end

    assign prod_next = a_val * b_part;

    // accumulate the registered product in the cycle after the multiply
    assign prod_ext = ACC_W'(prod_reg);
    assign term     = pop_reg.hi ? {prod_ext[ACC_W-1-B_LO_W:0], {B_LO_W{1'b0}}} : prod_ext;
    assign acc_sum  = pop_reg.neg ? (acc_reg - term) : (acc_reg + term);

    always_comb
    begin
        acc_next = acc_reg;
        res_next = res_reg;
        if (pend_reg)
        begin
            if (pop_reg.last)
            begin
                acc_next = '0;
                unique case (pop_reg.dst)
                    D_XX:    res_next.xx   = acc_sum[XX_W-1:0];
                    D_XY:    res_next.xy   = acc_sum[XX_W-1:0];
                    D_DEN:   res_next.den  = acc_sum[DEN_W-1:0];
                    D_SNUM:  res_next.snum = acc_sum[DEN_W-1:0];
                    D_INUM:  res_next.inum = acc_sum;
                    default: res_next      = res_reg;
                endcase
            end
            else
            begin
                acc_next = acc_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            pop_reg  <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            pend_reg <= issue;
            pop_reg  <= op;
            acc_reg  <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        res_reg  <= res_next;
    end

    assign res = res_reg;

endmodule

`default_nettype wire

[src/rlsf_div.sv]
`default_nettype none

module rlsf_div (
    input  logic               clk,
    input  logic               rst_n,
    input  rlsf_pkg::div_req_t req,
    output rlsf_pkg::div_rsp_t rsp
);
    import rlsf_pkg::*;

    typedef enum logic [3:0] {
        D_IDLE = 4'b0001,
        D_PRE  = 4'b0010,
        D_ITER = 4'b0100,
        D_FIN  = 4'b1000
    } dstate_t;

    dstate_t              st_reg;
    dstate_t              st_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic [ACC_W-1:0]     n_reg;
    logic [ACC_W-1:0]     n_next;
    logic [DEN_W-1:0]     b_reg;
    logic [DEN_W-1:0]     b_next;
    logic [DEN_W-1:0]     r_reg;
    logic [DEN_W-1:0]     r_next;
    logic [Q_W-1:0]       q_reg;
    logic [Q_W-1:0]       q_next;
    logic                 neg_reg;
    logic                 neg_next;
    logic                 sat_reg;
    logic                 sat_next;
    logic                 done_reg;
    logic                 done_next;
    logic [Q_W-1:0]       quo_reg;
    logic [Q_W-1:0]       quo_next;

    logic [ACC_W-1:0]     num_mag;
    logic [ACC_W-1:0]     num_sh;
    logic [DEN_W-1:0]     den_mag;
    logic [DEN_W:0]       rs;
    logic [DEN_W:0]       diff;
    logic                 ge;
    logic [Q_W-1:0]       limit;
    logic [Q_W-1:0]       qm;

    assign num_mag = req.num[ACC_W-1] ? (~req.num + 1'b1) : req.num;
    assign num_sh  = req.frac ? (num_mag << SLOPE_FRAC) : num_mag;
    assign den_mag = req.den[DEN_W-1] ? (~req.den + 1'b1) : req.den;

    // one quotient bit a cycle
    assign rs    = {r_reg, n_reg[Q_W-1]};
    assign diff  = rs - {1'b0, b_reg};
    assign ge    = rs >= {1'b0, b_reg};

    assign limit = neg_reg ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
    assign qm    = (sat_reg || (q_reg > limit)) ? limit : q_reg;

    always_comb
    begin
        st_next   = st_reg;
        cnt_next  = cnt_reg;
        n_next    = n_reg;
        b_next    = b_reg;
        r_next    = r_reg;
        q_next    = q_reg;
        neg_next  = neg_reg;
        sat_next  = sat_reg;
        quo_next  = quo_reg;
        done_next = 1'b0;
        unique case (st_reg)
            D_IDLE:
            begin
                if (req.start)
                begin
                    n_next   = num_sh;
                    b_next   = den_mag;
                    neg_next = req.num[ACC_W-1] ^ req.den[DEN_W-1];
                    st_next  = D_PRE;
                end
            end
            D_PRE:
            begin
                // quotient of 2^32 or more saturates
                sat_next = DEN_W'(n_reg[ACC_W-1:Q_W]) >= b_reg;
                r_next   = DEN_W'(n_reg[ACC_W-1:Q_W]);
                cnt_next = '0;
                st_next  = D_ITER;
            end
            D_ITER:
            begin
                r_next   = ge ? diff[DEN_W-1:0] : rs[DEN_W-1:0];
                q_next   = {q_reg[Q_W-2:0], ge};
                n_next   = {n_reg[ACC_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(Q_W - 1))
                begin
                    st_next = D_FIN;
                end
            end
            D_FIN:
            begin
                quo_next  = neg_reg ? (~qm + 1'b1) : qm;
                done_next = 1'b1;
                st_next   = D_IDLE;
            end
            default:
            begin
                st_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= D_IDLE;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        b_reg   <= b_next;
        r_reg   <= r_next;
        q_reg   <= q_next;
        neg_reg <= neg_next;
        sat_reg <= sat_next;
        quo_reg <= quo_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

`default_nettype wire

[src/running_least_squares_line_fit.sv]
`default_nettype none

// channel   direction  handshake            payload
// request   in         in_valid / in_stall   command, x, y
// result    out        out_valid / out_stall slope, intercept, count, status
//
// one request at a time; the fit is divided unless the set is empty or the denominator is zero
// the time from accept to result is set by the 16 multiply steps of the shared multiplier
// and, when the fit is divided, two 32-step divider runs
// in_stall is high from accept until the result is loaded into the output register
// a pending result may wait on out_stall while the next request is accepted
// reset clears the sums, the count and both handshakes

module running_least_squares_line_fit (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [rlsf_pkg::CMD_W-1:0]              command,
    input  logic signed [rlsf_pkg::COORD_WIDTH-1:0] x,
    input  logic signed [rlsf_pkg::COORD_WIDTH-1:0] y,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [rlsf_pkg::Q_W-1:0]         slope,
    output logic signed [rlsf_pkg::Q_W-1:0]         intercept,
    output logic [rlsf_pkg::CNT_W-1:0]              count,
    output logic [rlsf_pkg::ST_W-1:0]               status
);
    import rlsf_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_MUL1   = 10'b0000000010,
        S_DRAIN1 = 10'b0000000100,
        S_UPD    = 10'b0000001000,
        S_MUL2   = 10'b0000010000,
        S_DRAIN2 = 10'b0000100000,
        S_CHECK  = 10'b0001000000,
        S_DIVS   = 10'b0010000000,
        S_DIVI   = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    logic [STEP_W-1:0]       step_reg;
    logic [STEP_W-1:0]       step_next;
    logic [CMD_W-1:0]        cmd_reg;
    logic [CMD_W-1:0]        cmd_next;
    logic signed [COORD_WIDTH-1:0] x_reg;
    logic signed [COORD_WIDTH-1:0] x_next;
    logic signed [COORD_WIDTH-1:0] y_reg;
    logic signed [COORD_WIDTH-1:0] y_next;

    logic [SX_W-1:0]         sx_reg;
    logic [SX_W-1:0]         sx_next;
    logic [SX_W-1:0]         sy_reg;
    logic [SX_W-1:0]         sy_next;
    logic [SXX_W-1:0]        sxx_reg;
    logic [SXX_W-1:0]        sxx_next;
    logic [SXY_W-1:0]        sxy_reg;
    logic [SXY_W-1:0]        sxy_next;
    logic [CNT_W-1:0]        pts_reg;
    logic [CNT_W-1:0]        pts_next;

    logic [ST_W-1:0]         stat_reg;
    logic [ST_W-1:0]         stat_next;
    logic [Q_W-1:0]          slope_reg;
    logic [Q_W-1:0]          slope_next;
    logic [Q_W-1:0]          icpt_reg;
    logic [Q_W-1:0]          icpt_next;

    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [Q_W-1:0]          out_slope_reg;
    logic [Q_W-1:0]          out_icpt_reg;
    logic [CNT_W-1:0]        out_count_reg;
    logic [ST_W-1:0]         out_status_reg;

    logic                    in_fire;
    logic                    out_free;
    logic                    out_load;
    logic                    mac_issue;
    logic                    fit_go;
    sums_t                   sums;
    mac_res_t                mac_res;
    div_req_t                div_req;
    div_rsp_t                div_rsp;

    logic [SX_W-1:0]         x_ext;
    logic [SX_W-1:0]         y_ext;
    logic [SXX_W-1:0]        xx_ext;
    logic [SXY_W-1:0]        xy_ext;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_load  = (state_reg == S_DONE) && out_free;
    assign mac_issue = (state_reg == S_MUL1) || (state_reg == S_MUL2);

    assign sums = '{n: pts_reg, sx: sx_reg, sy: sy_reg, sxx: sxx_reg, sxy: sxy_reg};

    assign x_ext  = SX_W'(x_reg);
    assign y_ext  = SX_W'(y_reg);
    assign xx_ext = SXX_W'(mac_res.xx);
    assign xy_ext = SXY_W'($signed(mac_res.xy));

    assign fit_go = (pts_reg != '0) && (mac_res.den != '0);

    always_comb
    begin
        div_req.start = ((state_reg == S_CHECK) && fit_go) ||
                        ((state_reg == S_DIVS) && div_rsp.done);
        div_req.frac  = (state_reg == S_CHECK);
        div_req.num   = (state_reg == S_CHECK) ? ACC_W'($signed(mac_res.snum)) : mac_res.inum;
        div_req.den   = mac_res.den;
    end

    rlsf_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .issue (mac_issue),
        .step  (step_reg),
        .x     (x_reg),
        .y     (y_reg),
        .sums  (sums),
        .res   (mac_res)
    );

    rlsf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd_next   = cmd_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        sxx_next   = sxx_reg;
        sxy_next   = sxy_reg;
        pts_next   = pts_reg;
        stat_next  = stat_reg;
        slope_next = slope_reg;
        icpt_next  = icpt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_next   = command;
                    x_next     = x;
                    y_next     = y;
                    step_next  = '0;
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_XY_LAST)
                begin
                    state_next = S_DRAIN1;
                end
            end
            S_DRAIN1:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                stat_next = ST_OK;
                unique case (cmd_reg)
                    CMD_ADD:
                    begin
                        if (pts_reg >= MAX_POINTS)
                        begin
                            stat_next = ST_REJECT;
                        end
                        else
                        begin
                            sx_next  = sx_reg + x_ext;
                            sy_next  = sy_reg + y_ext;
                            sxx_next = sxx_reg + xx_ext;
                            sxy_next = sxy_reg + xy_ext;
                            pts_next = pts_reg + 1'b1;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (pts_reg <= CNT_W'(1))
                        begin
                            stat_next = ST_REJECT;
                        end
                        else
                        begin
                            sx_next  = sx_reg - x_ext;
                            sy_next  = sy_reg - y_ext;
                            sxx_next = sxx_reg - xx_ext;
                            sxy_next = sxy_reg - xy_ext;
                            pts_next = pts_reg - 1'b1;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        sx_next  = '0;
                        sy_next  = '0;
                        sxx_next = '0;
                        sxy_next = '0;
                        pts_next = '0;
                    end
                    default:
                    begin
                        stat_next = ST_REJECT;
                    end
                endcase
                step_next  = STEP_FIT_FIRST;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_FIT_LAST)
                begin
                    state_next = S_DRAIN2;
                end
            end
            S_DRAIN2:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (pts_reg == '0)
                begin
                    slope_next = '0;
                    icpt_next  = '0;
                    if (stat_reg == ST_OK)
                    begin
                        stat_next = ST_EMPTY;
                    end
                    state_next = S_DONE;
                end
                else if (mac_res.den == '0)
                begin
                    slope_next = '0;
                    icpt_next  = '0;
                    if (stat_reg == ST_OK)
                    begin
                        stat_next = ST_DEGEN;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_DIVS;
                end
            end
            S_DIVS:
            begin
                if (div_rsp.done)
                begin
                    slope_next = div_rsp.quo;
                    state_next = S_DIVI;
                end
            end
            S_DIVI:
            begin
                if (div_rsp.done)
                begin
                    icpt_next  = div_rsp.quo;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            sx_reg        <= '0;
            sy_reg        <= '0;
            sxx_reg       <= '0;
            sxy_reg       <= '0;
            pts_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            sx_reg        <= sx_next;
            sy_reg        <= sy_next;
            sxx_reg       <= sxx_next;
            sxy_reg       <= sxy_next;
            pts_reg       <= pts_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        stat_reg  <= stat_next;
        slope_reg <= slope_next;
        icpt_reg  <= icpt_next;
        if (out_load)
        begin
            out_slope_reg  <= slope_reg;
            out_icpt_reg   <= icpt_reg;
            out_count_reg  <= pts_reg;
            out_status_reg <= stat_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign slope     = out_slope_reg;
    assign intercept = out_icpt_reg;
    assign count     = out_count_reg;
    assign status    = out_status_reg;

endmodule

`default_nettype wire
